### rtl/chunk_container_preview_extractor_defines.svh
// assertion macros for the chunk container preview extractor
// used by the rtl files that carry assertions; expects clk and rst in scope
`ifndef CHUNK_CONTAINER_PREVIEW_EXTRACTOR_DEFINES_SVH
`define CHUNK_CONTAINER_PREVIEW_EXTRACTOR_DEFINES_SVH

`ifndef ASSERT_OFF

`define CCPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define CCPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define CCPE_ASSERT(lbl, prop, msg)

`define CCPE_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/ccpe_pkg.sv
// shared types and constants for the chunk container preview extractor
// no dependencies
package ccpe_pkg;

  localparam logic [7:0] CHUNK_ID_MAX      = 8'd15;
  localparam logic [7:0] COMPRESSION_NONE  = 8'd0;
  localparam logic [7:0] CHUNK_ID_PREVIEW  = 8'd1;
  localparam logic [2:0] SKIP_HEADER_BYTES = 3'd4;

  localparam logic [32:0] CONSUMED_MAX = {33{1'b1}};

  localparam logic [3:0] PH_COMP      = 4'd0;
  localparam logic [3:0] PH_BODY      = 4'd1;
  localparam logic [3:0] PH_RAW       = 4'd2;
  localparam logic [3:0] PH_ID        = 4'd3;
  localparam logic [3:0] PH_SKIP_SIZE = 4'd4;
  localparam logic [3:0] PH_SKIP      = 4'd5;
  localparam logic [3:0] PH_PREV_SIZE = 4'd6;
  localparam logic [3:0] PH_PAYLOAD   = 4'd7;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_BAD_COMP  = 3'd2;
  localparam logic [2:0] ST_MISMATCH  = 3'd3;
  localparam logic [2:0] ST_BAD_ID    = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       payload_last;
    logic       status_valid;
    logic [2:0] status_code;
  } ccpe_result_t;

endpackage

### rtl/ccpe_parser.sv
// byte-wise header and chunk parser, one byte per accepted transaction
// depends on ccpe_pkg and the assertion macro header
`include "chunk_container_preview_extractor_defines.svh"

module ccpe_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  frame_start,
  output logic                  res_valid,
  output ccpe_pkg::ccpe_result_t res
);
  import ccpe_pkg::*;

  logic [3:0]  phase;
  logic [1:0]  field_byte_count;
  logic [31:0] body_size;
  logic [31:0] raw_size;
  logic [32:0] bytes_consumed;
  logic [31:0] chunk_remaining;
  logic        finished;

  logic [3:0]  phase_next;
  logic [1:0]  field_byte_count_next;
  logic [31:0] body_size_next;
  logic [31:0] raw_size_next;
  logic [32:0] bytes_consumed_next;
  logic [31:0] chunk_remaining_next;
  logic        finished_next;

  logic [3:0]  cur_phase;
  logic [1:0]  cur_fbc;
  logic [31:0] cur_body;
  logic [31:0] cur_raw;
  logic [32:0] cur_cons;
  logic [31:0] cur_rem;
  logic        cur_fin;

  logic [31:0] body_ins;
  logic [31:0] raw_ins;
  logic [31:0] rem_ins;
  logic [31:0] rem_dec;
  logic        field_end;
  logic [33:0] cons_inc;
  logic [32:0] cons_inc_sat;
  logic [34:0] cons_skip;
  logic [32:0] cons_skip_sat;

  ccpe_result_t res_c;
  logic         res_valid_c;

  always_comb begin
    if (frame_start) begin
      cur_phase = PH_COMP;
      cur_fbc   = 2'd0;
      cur_body  = 32'd0;
      cur_raw   = 32'd0;
      cur_cons  = 33'd0;
      cur_rem   = 32'd0;
      cur_fin   = 1'b0;
    end else begin
      cur_phase = phase;
      cur_fbc   = field_byte_count;
      cur_body  = body_size;
      cur_raw   = raw_size;
      cur_cons  = bytes_consumed;
      cur_rem   = chunk_remaining;
      cur_fin   = finished;
    end
  end

  // little-endian field assembly and counter arithmetic
  always_comb begin
    body_ins = cur_body;
    body_ins[{cur_fbc, 3'b000} +: 8] = data_byte;
    raw_ins = cur_raw;
    raw_ins[{cur_fbc, 3'b000} +: 8] = data_byte;
    rem_ins = cur_rem;
    rem_ins[{cur_fbc, 3'b000} +: 8] = data_byte;
    rem_dec   = cur_rem - 32'd1;
    field_end = (cur_fbc == 2'd3);
    cons_inc  = {1'b0, cur_cons} + 34'd1;
    cons_inc_sat = cons_inc[33] ? CONSUMED_MAX : cons_inc[32:0];
    cons_skip = {2'b00, cur_cons} + {32'd0, SKIP_HEADER_BYTES} + {3'b000, rem_ins};
    cons_skip_sat = (cons_skip[34:33] != 2'b00) ? CONSUMED_MAX : cons_skip[32:0];
  end

  always_comb begin
    phase_next            = cur_phase;
    field_byte_count_next = cur_fbc;
    body_size_next        = cur_body;
    raw_size_next         = cur_raw;
    bytes_consumed_next   = cur_cons;
    chunk_remaining_next  = cur_rem;
    finished_next         = cur_fin;
    res_valid_c           = 1'b0;
    res_c                 = '0;
    if (!cur_fin) begin
      case (cur_phase)
        PH_COMP: begin
          if (data_byte != COMPRESSION_NONE) begin
            res_valid_c = 1'b1;
            res_c.status_valid = 1'b1;
            res_c.status_code  = ST_BAD_COMP;
            finished_next = 1'b1;
          end else begin
            field_byte_count_next = 2'd0;
            phase_next = PH_BODY;
          end
        end
        PH_BODY: begin
          body_size_next = body_ins;
          field_byte_count_next = cur_fbc + 2'd1;
          if (field_end) phase_next = PH_RAW;
        end
        PH_RAW: begin
          raw_size_next = raw_ins;
          field_byte_count_next = cur_fbc + 2'd1;
          if (field_end) begin
            bytes_consumed_next = 33'd0;
            if (raw_ins != cur_body) begin
              res_valid_c = 1'b1;
              res_c.status_valid = 1'b1;
              res_c.status_code  = ST_MISMATCH;
              finished_next = 1'b1;
            end else if (cur_body == 32'd0) begin
              res_valid_c = 1'b1;
              res_c.status_valid = 1'b1;
              res_c.status_code  = ST_NOT_FOUND;
              finished_next = 1'b1;
            end else begin
              phase_next = PH_ID;
            end
          end
        end
        PH_ID: begin
          bytes_consumed_next = cons_inc_sat;
          if (data_byte == 8'd0 || data_byte >= CHUNK_ID_MAX) begin
            res_valid_c = 1'b1;
            res_c.status_valid = 1'b1;
            res_c.status_code  = ST_BAD_ID;
            finished_next = 1'b1;
          end else begin
            field_byte_count_next = 2'd0;
            phase_next = (data_byte == CHUNK_ID_PREVIEW) ? PH_PREV_SIZE : PH_SKIP_SIZE;
          end
        end
        PH_SKIP_SIZE: begin
          chunk_remaining_next = rem_ins;
          field_byte_count_next = cur_fbc + 2'd1;
          if (field_end) begin
            bytes_consumed_next = cons_skip_sat;
            if (rem_ins != 32'd0) begin
              phase_next = PH_SKIP;
            end else if (cons_skip_sat >= {1'b0, cur_body}) begin
              res_valid_c = 1'b1;
              res_c.status_valid = 1'b1;
              res_c.status_code  = ST_NOT_FOUND;
              finished_next = 1'b1;
            end else begin
              phase_next = PH_ID;
            end
          end
        end
        PH_SKIP: begin
          chunk_remaining_next = rem_dec;
          if (rem_dec == 32'd0) begin
            if (cur_cons >= {1'b0, cur_body}) begin
              res_valid_c = 1'b1;
              res_c.status_valid = 1'b1;
              res_c.status_code  = ST_NOT_FOUND;
              finished_next = 1'b1;
            end else begin
              phase_next = PH_ID;
            end
          end
        end
        PH_PREV_SIZE: begin
          chunk_remaining_next = rem_ins;
          field_byte_count_next = cur_fbc + 2'd1;
          if (field_end) begin
            if (rem_ins == 32'd0) begin
              res_valid_c = 1'b1;
              res_c.status_valid = 1'b1;
              res_c.status_code  = ST_EMPTY;
              finished_next = 1'b1;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          chunk_remaining_next = rem_dec;
          res_valid_c = 1'b1;
          res_c.payload_valid = 1'b1;
          res_c.payload_byte  = data_byte;
          if (rem_dec == 32'd0) begin
            res_c.payload_last = 1'b1;
            res_c.status_valid = 1'b1;
            res_c.status_code  = ST_FOUND;
            finished_next = 1'b1;
          end
        end
        default: begin
          phase_next = PH_COMP;
        end
      endcase
    end
  end

  assign res_valid = res_valid_c;
  assign res       = res_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_COMP;
      field_byte_count <= 2'd0;
      body_size        <= 32'd0;
      raw_size         <= 32'd0;
      bytes_consumed   <= 33'd0;
      chunk_remaining  <= 32'd0;
      finished         <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      body_size        <= body_size_next;
      raw_size         <= raw_size_next;
      bytes_consumed   <= bytes_consumed_next;
      chunk_remaining  <= chunk_remaining_next;
      finished         <= finished_next;
    end
  end

  `CCPE_ASSERT(a_fin_silent, !(accept && finished && !frame_start && res_valid), "result after finish")
  `CCPE_ASSERT(a_last_has_status, !(res_valid && res.payload_last) || (res.status_valid && res.status_code == ST_FOUND), "last byte without found status")
  `CCPE_ASSERT_NEXT(a_status_finishes, accept && res_valid && res.status_valid, finished, "status did not finish parse")

endmodule

### rtl/ccpe_out_buf.sv
// two-entry result buffer between the parser and the output channel
// depends on ccpe_pkg and the assertion macro header
`include "chunk_container_preview_extractor_defines.svh"

module ccpe_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ccpe_pkg::ccpe_result_t push_data,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ccpe_pkg::ccpe_result_t out_data
);
  import ccpe_pkg::*;

  logic         main_valid;
  ccpe_result_t main_data;
  logic         skid_valid;
  ccpe_result_t skid_data;
  logic         pop;

  assign pop       = main_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          main_valid <= push;
        end
      end else if (push) begin
        if (!main_valid) begin
          main_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      main_data <= skid_data;
    end else if (push && (pop || !main_valid)) begin
      main_data <= push_data;
    end
    if (push && main_valid && !pop) begin
      skid_data <= push_data;
    end
  end

  `CCPE_ASSERT(a_skid_implies_main, !skid_valid || main_valid, "skid full with main empty")
  `CCPE_ASSERT(a_no_push_when_full, !(push && skid_valid), "transaction pushed into full buffer")
  `CCPE_ASSERT_NEXT(a_stall_fills_skid, push && main_valid && !out_ready, skid_valid, "stalled result lost")
  `CCPE_ASSERT_NEXT(a_skid_drains, skid_valid && out_ready, main_valid && !skid_valid, "skid entry not moved")

endmodule

### rtl/chunk_container_preview_extractor.sv
// Preview extractor for a chunked container byte stream. One byte is accepted per
// cycle, every cycle, for as long as the two-entry result buffer has room; a byte that
// produces a payload byte or a status is registered in the result buffer and appears on
// the output channel from there. The rate is set by the combinational parser update (a
// 35-bit add with saturation and a 33-bit compare at the end of a skipped chunk's size
// field); input ready drops only while both result buffer entries are held by a
// stalled output. Header and size fields are little-endian; frame_start restarts the
// parse on its byte. Depends on ccpe_pkg, ccpe_parser and ccpe_out_buf.
module chunk_container_preview_extractor (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       payload_valid,
  output logic [7:0] payload_byte,
  output logic       payload_last,
  output logic       status_valid,
  output logic [2:0] status_code
);
  import ccpe_pkg::*;

  logic         accept;
  logic         res_valid;
  ccpe_result_t res;
  logic         space;
  ccpe_result_t out_data;

  assign in_ready = space;
  assign accept   = in_valid && space;

  ccpe_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  ccpe_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign payload_valid = out_data.payload_valid;
  assign payload_byte  = out_data.payload_byte;
  assign payload_last  = out_data.payload_last;
  assign status_valid  = out_data.status_valid;
  assign status_code   = out_data.status_code;

endmodule
